/* sv/jcfb_pkg.sv */
package jcfb_pkg;

	localparam int NUM_JOINTS = 5;
	localparam int BLOCK_LEN  = 9;
	localparam int HEADER_LEN = 4;
	localparam int FRAME_LEN  = HEADER_LEN + NUM_JOINTS * BLOCK_LEN + 2;
	localparam int CKS_POS    = FRAME_LEN - 2;
	localparam int LAST_POS   = FRAME_LEN - 1;
	localparam int LIMIT_W    = 12;
	localparam int TABLE_W    = NUM_JOINTS * LIMIT_W;
	localparam int REG_IDX_W  = 1;

	localparam logic [7:0] HEADER_BYTE = 8'd231;
	localparam logic [7:0] FOOTER_BYTE = 8'd229;

	localparam logic [TABLE_W-1:0] TABLE_RESET = '1;

	localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_CURRENT_LIMIT = 1'd1;

	localparam logic [2:0] MODE_HOLD    = 3'd0;
	localparam logic [2:0] MODE_PWM_CW  = 3'd1;
	localparam logic [2:0] MODE_PWM_CCW = 3'd2;
	localparam logic [2:0] MODE_SPD_CW  = 3'd3;
	localparam logic [2:0] MODE_SPD_CCW = 3'd4;
	localparam logic [2:0] MODE_POS     = 3'd5;

	localparam int DEMAND_MAX = 4095;
	localparam int PWM_MAX    = 100;
	// pwm code = 655*d + floor((18*d + 25) / 50) - 1 for d > 0
	localparam int PWM_K      = 655;
	localparam int PWM_FRAC   = 18;
	localparam int PWM_OFS    = 25;
	localparam int PWM_RECIP  = 1311;
	localparam int PWM_SHIFT  = 16;

	typedef logic [BLOCK_LEN-1:0][7:0] block_t;

	typedef struct packed {
		logic       vld;
		logic       cks;
		logic       last;
		logic [7:0] data;
	} cell_t;

endpackage

/* sv/joint_command_frame_builder_top.sv */
// an accepted command loads the chain; bytes leave cell 0 through the output register
// one frame byte per cycle while out_ready is held high, through a 51-cell shift chain
// the next command loads while the previous footer byte leaves, so frames run back to back
// reset: chain and output register empty, both limit tables all ones (4095 per joint)
module joint_command_frame_builder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [jcfb_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [jcfb_pkg::TABLE_W-1:0]        wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          joint0_type,
	input  logic signed [16:0]                  joint0_demand,
	input  logic [2:0]                          joint1_type,
	input  logic signed [16:0]                  joint1_demand,
	input  logic [2:0]                          joint2_type,
	input  logic signed [16:0]                  joint2_demand,
	input  logic [2:0]                          joint3_type,
	input  logic signed [16:0]                  joint3_demand,
	input  logic [2:0]                          joint4_type,
	input  logic signed [16:0]                  joint4_demand,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          frame_byte,
	output logic                                last_byte
);
	import jcfb_pkg::*;

	logic [TABLE_W-1:0] speed_q;
	logic [TABLE_W-1:0] current_q;

	logic [2:0]         jt    [NUM_JOINTS];
	logic signed [16:0] jd    [NUM_JOINTS];
	block_t             blk   [NUM_JOINTS];
	logic [7:0]         frame [FRAME_LEN];
	cell_t              chain [FRAME_LEN];
	logic [FRAME_LEN-1:0] last_flags;

	logic       advance;
	logic       accept;
	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       last_byte_q;
	logic [7:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= TABLE_RESET;
			current_q <= TABLE_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_SPEED_LIMIT) begin
				speed_q <= wr_data;
			end
			if (wr_index == REG_CURRENT_LIMIT) begin
				current_q <= wr_data;
			end
		end
	end

	assign jt[0] = joint0_type;
	assign jt[1] = joint1_type;
	assign jt[2] = joint2_type;
	assign jt[3] = joint3_type;
	assign jt[4] = joint4_type;
	assign jd[0] = joint0_demand;
	assign jd[1] = joint1_demand;
	assign jd[2] = joint2_demand;
	assign jd[3] = joint3_demand;
	assign jd[4] = joint4_demand;

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
		jcfb_joint u_joint (
			.jtype   (jt[j]),
			.demand  (jd[j]),
			.spd_lim (speed_q[j*LIMIT_W +: LIMIT_W]),
			.cur_lim (current_q[j*LIMIT_W +: LIMIT_W]),
			.blk     (blk[j])
		);
	end

	always_comb begin
		frame[0] = HEADER_BYTE;
		for (int k = 1; k < HEADER_LEN; k++) begin
			frame[k] = 8'd0;
		end
		for (int j = 0; j < NUM_JOINTS; j++) begin
			for (int k = 0; k < BLOCK_LEN; k++) begin
				frame[HEADER_LEN + j*BLOCK_LEN + k] = blk[j][k];
			end
		end
		frame[CKS_POS]  = 8'd0;
		frame[LAST_POS] = FOOTER_BYTE;
	end

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance && !chain[1].vld;
	assign accept   = in_valid && in_ready;

	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
		cell_t ld_c;
		cell_t nxt_c;

		assign ld_c = '{vld: 1'b1, cks: (i == CKS_POS), last: (i == LAST_POS),
			data: frame[i]};

		if (i == LAST_POS) begin : g_tail
			assign nxt_c = '0;
		end else begin : g_body
			assign nxt_c = chain[i+1];
		end

		jcfb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (accept),
			.shift  (advance),
			.ld     (ld_c),
			.nxt    (nxt_c),
			.cur    (chain[i])
		);

		assign last_flags[i] = chain[i].vld && chain[i].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else if (advance) begin
			out_valid_q <= chain[0].vld;
			if (chain[0].vld) begin
				sum_q <= chain[0].last ? 8'd0 : sum_q + chain[0].data;
			end
		end
	end

	// checksum reduces to the byte sum modulo 256
	always_ff @(posedge clk) begin
		if (advance && chain[0].vld) begin
			frame_byte_q <= chain[0].cks ? sum_q : chain[0].data;
			last_byte_q  <= chain[0].last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	a_load_tail: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> chain[LAST_POS].vld && chain[LAST_POS].last)
		else $error("frame tail not loaded");

	a_footer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> frame_byte == FOOTER_BYTE)
		else $error("last item is not the footer");

	a_one_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(last_flags))
		else $error("more than one frame end in chain");

	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte && $past(advance) |-> sum_q == 8'd0)
		else $error("checksum accumulator not cleared at frame end");

endmodule

/* sv/jcfb_joint.sv */
module jcfb_joint (
	input  logic [2:0]                       jtype,
	input  logic signed [16:0]               demand,
	input  logic [jcfb_pkg::LIMIT_W-1:0]     spd_lim,
	input  logic [jcfb_pkg::LIMIT_W-1:0]     cur_lim,
	output jcfb_pkg::block_t                 blk
);
	import jcfb_pkg::*;

	logic [2:0]  mode_eff;
	logic [11:0] dem_c;
	logic [6:0]  pwm_d;
	logic [15:0] p_int;
	logic [10:0] x_frac;
	logic [21:0] p_frac;
	logic [16:0] pwm_sum;
	logic [15:0] code;

	assign mode_eff = (jtype == MODE_POS) ? MODE_HOLD : jtype;

	always_comb begin
		if (demand[16]) begin
			dem_c = '0;
		end else if (demand[15:12] != 4'd0) begin
			dem_c = 12'(DEMAND_MAX);
		end else begin
			dem_c = demand[11:0];
		end
	end

	assign pwm_d   = (dem_c > 12'(PWM_MAX)) ? 7'(PWM_MAX) : dem_c[6:0];
	assign p_int   = 16'(pwm_d) * 16'(PWM_K);
	assign x_frac  = 11'(pwm_d) * 11'(PWM_FRAC) + 11'(PWM_OFS);
	assign p_frac  = 22'(x_frac) * 22'(PWM_RECIP);
	assign pwm_sum = 17'(p_int) + 17'(p_frac[21:PWM_SHIFT]) - 17'd1;

	always_comb begin
		if (mode_eff inside {MODE_PWM_CW, MODE_PWM_CCW}) begin
			code = (pwm_d == 7'd0) ? 16'd0 : pwm_sum[15:0];
		end else if (mode_eff inside {MODE_SPD_CW, MODE_SPD_CCW}) begin
			code = {4'd0, dem_c};
		end else begin
			code = '0;
		end
	end

	always_comb begin
		blk[0] = 8'd0;
		blk[1] = {5'd0, mode_eff};
		blk[2] = code[15:8];
		blk[3] = code[7:0];
		blk[4] = {4'd0, spd_lim[11:8]};
		blk[5] = spd_lim[7:0];
		blk[6] = {4'd0, cur_lim[11:8]};
		blk[7] = cur_lim[7:0];
		blk[8] = 8'd0;
	end

endmodule

/* sv/jcfb_cell.sv */
module jcfb_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            shift,
	input  jcfb_pkg::cell_t ld,
	input  jcfb_pkg::cell_t nxt,
	output jcfb_pkg::cell_t cur
);
	import jcfb_pkg::*;

	logic       vld_q;
	logic       cks_q;
	logic       last_q;
	logic [7:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= ld.vld;
		end else if (shift) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cks_q  <= ld.cks;
			last_q <= ld.last;
			data_q <= ld.data;
		end else if (shift) begin
			cks_q  <= nxt.cks;
			last_q <= nxt.last;
			data_q <= nxt.data;
		end
	end

	assign cur = '{vld: vld_q, cks: cks_q, last: last_q, data: data_q};

endmodule

/* dv/joint_command_frame_builder_top_tb.sv */
`timescale 1ns / 1ps

module joint_command_frame_builder_top_tb;
	import jcfb_pkg::*;

	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int DIR_ROWS = 6;
	localparam int PHASE_ITEMS = 40;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [16:0] demand;
	} joint_cmd_t;

	typedef joint_cmd_t [NUM_JOINTS-1:0] motion_cmd_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [5:0] pos;
	} frame_entry_t;

	// typed rows carry the expected mode byte and demand code
	typedef struct packed {
		logic [2:0]         mode;
		logic signed [16:0] demand;
		logic               typed;
		logic [2:0]         x_mode;
		logic [15:0]        x_code;
	} joint_case_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [TABLE_W-1:0]   wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           joint0_type;
	logic signed [16:0]   joint0_demand;
	logic [2:0]           joint1_type;
	logic signed [16:0]   joint1_demand;
	logic [2:0]           joint2_type;
	logic signed [16:0]   joint2_demand;
	logic [2:0]           joint3_type;
	logic signed [16:0]   joint3_demand;
	logic [2:0]           joint4_type;
	logic signed [16:0]   joint4_demand;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           frame_byte;
	logic                 last_byte;

	logic [TABLE_W-1:0] speed_tbl;
	logic [TABLE_W-1:0] current_tbl;
	frame_entry_t       pending_bytes[$];
	frame_entry_t       head_byte;
	int                 mismatches;
	int                 idle_cycles;
	int                 rx_gap;
	bit                 rx_stall_en;
	bit                 tx_stall_en;

	joint_case_t dir_tab [DIR_ROWS*NUM_JOINTS] = '{
		'{MODE_HOLD,    17'sd0,     1'b1, MODE_HOLD,    16'd0},
		'{MODE_PWM_CW,  17'sd100,   1'b1, MODE_PWM_CW,  16'd65535},
		'{MODE_PWM_CCW, 17'sd65535, 1'b1, MODE_PWM_CCW, 16'd65535},
		'{MODE_SPD_CW,  17'sd4095,  1'b1, MODE_SPD_CW,  16'd4095},
		'{MODE_SPD_CCW, 17'sd65535, 1'b1, MODE_SPD_CCW, 16'd4095},

		'{MODE_POS,     17'sd1234,  1'b1, MODE_HOLD,    16'd0},
		'{MODE_RSVD6,   17'sd500,   1'b1, MODE_RSVD6,   16'd0},
		'{MODE_RSVD7,   -17'sd1,    1'b1, MODE_RSVD7,   16'd0},
		'{MODE_SPD_CW,  17'h10000,  1'b1, MODE_SPD_CW,  16'd0},
		'{MODE_PWM_CW,  17'h10000,  1'b1, MODE_PWM_CW,  16'd0},

		'{MODE_PWM_CW,  17'sd0,     1'b1, MODE_PWM_CW,  16'd0},
		'{MODE_PWM_CCW, 17'sd1,     1'b1, MODE_PWM_CCW, 16'd654},
		'{MODE_SPD_CW,  17'sd4096,  1'b1, MODE_SPD_CW,  16'd4095},
		'{MODE_SPD_CCW, 17'sd0,     1'b1, MODE_SPD_CCW, 16'd0},
		'{MODE_HOLD,    17'sd65535, 1'b1, MODE_HOLD,    16'd0},

		'{MODE_PWM_CW,  17'sd99,    1'b0, MODE_HOLD,    16'd0},
		'{MODE_PWM_CCW, 17'sd101,   1'b0, MODE_HOLD,    16'd0},
		'{MODE_SPD_CW,  17'sd1,     1'b0, MODE_HOLD,    16'd0},
		'{MODE_SPD_CCW, 17'sd4094,  1'b0, MODE_HOLD,    16'd0},
		'{MODE_POS,     17'h10000,  1'b0, MODE_HOLD,    16'd0},

		'{MODE_PWM_CCW, 17'sd50,    1'b0, MODE_HOLD,    16'd0},
		'{MODE_SPD_CCW, 17'sd2048,  1'b0, MODE_HOLD,    16'd0},
		'{MODE_HOLD,    -17'sd1,    1'b0, MODE_HOLD,    16'd0},
		'{MODE_RSVD7,   17'sd65535, 1'b0, MODE_HOLD,    16'd0},
		'{MODE_POS,     17'sd65535, 1'b0, MODE_HOLD,    16'd0},

		'{MODE_SPD_CW,  17'h00aaa,  1'b0, MODE_HOLD,    16'd0},
		'{MODE_SPD_CCW, 17'h15555,  1'b0, MODE_HOLD,    16'd0},
		'{MODE_RSVD7,   17'sd0,     1'b0, MODE_HOLD,    16'd0},
		'{MODE_PWM_CW,  17'sd4095,  1'b0, MODE_HOLD,    16'd0},
		'{MODE_POS,     17'sd0,     1'b0, MODE_HOLD,    16'd0}
	};

	joint_command_frame_builder_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.joint0_type  (joint0_type),
		.joint0_demand(joint0_demand),
		.joint1_type  (joint1_type),
		.joint1_demand(joint1_demand),
		.joint2_type  (joint2_type),
		.joint2_demand(joint2_demand),
		.joint3_type  (joint3_type),
		.joint3_demand(joint3_demand),
		.joint4_type  (joint4_type),
		.joint4_demand(joint4_demand),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	// mode byte sent and 16-bit demand code for one joint
	function automatic logic [18:0] joint_demand_code(logic [2:0] mode,
			logic signed [16:0] demand);
		int          d;
		int          dv;
		int unsigned code;
		logic [2:0]  m;
		m = mode;
		code = 0;
		dv = int'(demand);
		if (m == MODE_POS) begin
			m = MODE_HOLD;
			d = 0;
		end else if (dv < 0) begin
			d = 0;
		end else if (dv > DEMAND_MAX) begin
			d = DEMAND_MAX;
		end else begin
			d = dv;
		end
		if (m == MODE_PWM_CW || m == MODE_PWM_CCW) begin
			if (d > PWM_MAX)
				d = PWM_MAX;
			// round(d * 655.36 - 1), zero stays zero
			code = (d == 0) ? 0 : (2 * (d * 16384 - 25) + 25) / 50;
		end else if (m == MODE_SPD_CW || m == MODE_SPD_CCW) begin
			code = d;
		end
		return {m, code[15:0]};
	endfunction

	function automatic frame_t build_frame(logic [NUM_JOINTS-1:0][2:0] modes,
			logic [NUM_JOINTS-1:0][15:0] codes);
		frame_t      f;
		int          sum;
		int          b;
		logic [31:0] cks;
		logic [11:0] sl;
		logic [11:0] cl;
		f = '0;
		f[0] = HEADER_BYTE;
		for (int j = 0; j < NUM_JOINTS; j++) begin
			b = HEADER_LEN + j * BLOCK_LEN;
			sl = speed_tbl[LIMIT_W*j +: LIMIT_W];
			cl = current_tbl[LIMIT_W*j +: LIMIT_W];
			f[b+1] = {5'd0, modes[j]};
			f[b+2] = codes[j][15:8];
			f[b+3] = codes[j][7:0];
			f[b+4] = {4'd0, sl[11:8]};
			f[b+5] = sl[7:0];
			f[b+6] = {4'd0, cl[11:8]};
			f[b+7] = cl[7:0];
		end
		sum = 0;
		for (int k = 0; k < CKS_POS; k++)
			sum += int'(f[k]);
		cks = (sum % 255) - (sum / 255);
		f[CKS_POS] = cks[7:0];
		f[LAST_POS] = FOOTER_BYTE;
		return f;
	endfunction

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_command(input motion_cmd_t c, input logic [NUM_JOINTS-1:0] typed,
			input logic [NUM_JOINTS-1:0][2:0] x_modes,
			input logic [NUM_JOINTS-1:0][15:0] x_codes);
		frame_t                      f;
		logic [NUM_JOINTS-1:0][2:0]  modes;
		logic [NUM_JOINTS-1:0][15:0] codes;
		logic [18:0]                 jc;
		bit                          took;
		for (int j = 0; j < NUM_JOINTS; j++) begin
			jc = joint_demand_code(c[j].mode, c[j].demand);
			modes[j] = typed[j] ? x_modes[j] : jc[18:16];
			codes[j] = typed[j] ? x_codes[j] : jc[15:0];
		end
		f = build_frame(modes, codes);
		in_valid <= 1'b1;
		joint0_type <= c[0].mode;
		joint0_demand <= c[0].demand;
		joint1_type <= c[1].mode;
		joint1_demand <= c[1].demand;
		joint2_type <= c[2].mode;
		joint2_demand <= c[2].demand;
		joint3_type <= c[3].mode;
		joint3_demand <= c[3].demand;
		joint4_type <= c[4].mode;
		joint4_demand <= c[4].demand;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			if (took) begin
				for (int k = 0; k < FRAME_LEN; k++)
					pending_bytes.push_back(frame_entry_t'{data: f[k],
						last: (k == LAST_POS), pos: 6'(k)});
			end
			@(posedge clk);
		end
	endtask

	task automatic drain_frames();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_table(input logic [REG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_SPEED_LIMIT)
			speed_tbl = val;
		else
			current_tbl = val;
		@(posedge clk);
	endtask

	task automatic run_items(input int n, input bit pause_midway);
		motion_cmd_t c;
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2) begin
				drain_frames();
			end else if (tx_stall_en && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
			for (int j = 0; j < NUM_JOINTS; j++) begin
				c[j].mode = 3'($urandom_range(0, 7));
				case ($urandom_range(0, 5))
					0: c[j].demand = 17'($urandom);
					1: c[j].demand = 17'($urandom_range(0, 4095));
					2: c[j].demand = 17'($urandom_range(0, 120));
					3: c[j].demand = 17'(-$urandom_range(1, 65536));
					4: c[j].demand = 17'($urandom_range(4096, 65535));
					default: begin
						case ($urandom_range(0, 9))
							0: c[j].demand = 17'sd0;
							1: c[j].demand = 17'sd1;
							2: c[j].demand = 17'sd99;
							3: c[j].demand = 17'sd100;
							4: c[j].demand = 17'sd101;
							5: c[j].demand = 17'sd4095;
							6: c[j].demand = 17'sd4096;
							7: c[j].demand = 17'sd65535;
							8: c[j].demand = -17'sd1;
							default: c[j].demand = 17'h10000;
						endcase
					end
				endcase
			end
			send_command(c, '0, '0, '0);
		end
	endtask

	// output side: random stalls on ready
	initial begin
		out_ready = 1'b0;
		rx_gap = 0;
		forever begin
			@(posedge clk);
			if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap--;
			end else begin
				out_ready <= 1'b1;
				if (rx_stall_en && $urandom_range(0, 5) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	// sample mid-cycle: what is seen here is what the next rising edge takes
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_bytes.size() == 0) begin
					$error("frame_byte: no byte expected, got %0d", frame_byte);
					mismatches++;
				end else begin
					head_byte = pending_bytes.pop_front();
					if (frame_byte !== head_byte.data) begin
						$error("frame_byte[%0d]: expected %0d, got %0d", head_byte.pos,
							head_byte.data, frame_byte);
						mismatches++;
					end
					if (last_byte !== head_byte.last) begin
						$error("last_byte[%0d]: expected %0d, got %0d", head_byte.pos,
							head_byte.last, last_byte);
						mismatches++;
					end
				end
			end
			if ((out_valid && out_ready) || (in_valid && in_ready) || wr_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	initial begin
		motion_cmd_t                 c;
		logic [NUM_JOINTS-1:0]       typed;
		logic [NUM_JOINTS-1:0][2:0]  x_modes;
		logic [NUM_JOINTS-1:0][15:0] x_codes;
		joint_case_t                 jcase;
		logic [TABLE_W-1:0]          spd_set [4];
		logic [TABLE_W-1:0]          cur_set [4];

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		joint0_type = '0;
		joint0_demand = '0;
		joint1_type = '0;
		joint1_demand = '0;
		joint2_type = '0;
		joint2_demand = '0;
		joint3_type = '0;
		joint3_demand = '0;
		joint4_type = '0;
		joint4_demand = '0;
		speed_tbl = TABLE_RESET;
		current_tbl = TABLE_RESET;
		mismatches = 0;
		idle_cycles = 0;
		rx_stall_en = 1'b1;
		tx_stall_en = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: reset limits with random ready stalls, then zero limits without
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) begin
				drain_frames();
				write_table(REG_SPEED_LIMIT, '0);
				write_table(REG_CURRENT_LIMIT, '0);
				rx_stall_en = 1'b0;
			end
			for (int r = 0; r < DIR_ROWS; r++) begin
				for (int j = 0; j < NUM_JOINTS; j++) begin
					jcase = dir_tab[r*NUM_JOINTS+j];
					c[j].mode = jcase.mode;
					c[j].demand = jcase.demand;
					typed[j] = jcase.typed;
					x_modes[j] = jcase.x_mode;
					x_codes[j] = jcase.x_code;
				end
				send_command(c, typed, x_modes, x_codes);
			end
		end

		spd_set[0] = TABLE_RESET;
		cur_set[0] = TABLE_RESET;
		spd_set[1] = TABLE_W'({$urandom, $urandom});
		cur_set[1] = TABLE_W'({$urandom, $urandom});
		spd_set[2] = {(TABLE_W/4){4'h5}};
		cur_set[2] = {(TABLE_W/4){4'ha}};
		spd_set[3] = TABLE_W'({$urandom, $urandom});
		cur_set[3] = '0;

		for (int p = 0; p < 4; p++) begin
			drain_frames();
			write_table(REG_SPEED_LIMIT, spd_set[p]);
			write_table(REG_CURRENT_LIMIT, cur_set[p]);
			rx_stall_en = (p != 2);
			tx_stall_en = (p != 2);
			run_items(PHASE_ITEMS, p == 1);
		end

		drain_frames();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
